// File: src/ssdp_pkg.sv
// ----------------------------------------------------------------------------
// ssdp_pkg
// Shared types and constants for the subset-sum solver: default sizes,
// field widths, the table entry layout and stream beat widths.
// ----------------------------------------------------------------------------
package ssdp_pkg;

	// default sizes, handed to the top level parameters
	localparam int MAX_ELEMS_DEF   = 32;
	localparam int MAX_ABS_SUM_DEF = 8192;
	localparam int ELEM_MAG_DEF    = 255;

	// field widths fixed by the interface
	localparam int ELEM_W     = 9;
	localparam int TARGET_W   = 15;
	localparam int IDX_W      = 5;
	localparam int PARENT_W   = 6;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;

	// parent code for a sum that no element has reached
	localparam logic [PARENT_W-1:0] PARENT_NONE = '1;

	// one entry of the reachable-sum table
	typedef struct packed {
		logic                reach;
		logic [PARENT_W-1:0] parent;
	} entry_t;

endpackage

// File: src/ssdp_ram.sv
// ----------------------------------------------------------------------------
// ssdp_ram
// Generic RAM: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ssdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	// write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// File: src/subset_sum_dp_solver.sv
// ----------------------------------------------------------------------------
// subset_sum_dp_solver
// Subset-sum solver: builds a reachable-sum table element by element and
// walks the parent chain of the target sum to list the chosen elements.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one set element per beat (tdata[8:0] signed value, tlast
//   marks the final element of the set). target_sum is written through
//   cfg_wr_en / cfg_wr_data while the block is idle.
//   m_axis returns results: a verdict beat (tuser = 1) after the final
//   element, then, if the target is reachable, one beat per chosen element
//   index, latest first; tlast marks the final beat of the set.
//   Each element sweeps 2*MAX_ABS_SUM + 1 - |value| table entries, one
//   entry per cycle, through the two read ports and one write port of the
//   table memory; an element beyond capacity skips the sweep. The final
//   element is followed by the verdict and the solution indices, then a
//   clearing pass over all 2*MAX_ABS_SUM + 1 entries (16385 by default)
//   rewrites the table for the next set.
//   After reset the same clearing pass runs with s_axis_tready low.
//   A result waits in the output register while m_axis_tready is low; the
//   sequencer holds only when it has a further result to hand over.
// ----------------------------------------------------------------------------
module subset_sum_dp_solver #(
	parameter int MAX_ELEMS   = ssdp_pkg::MAX_ELEMS_DEF,
	parameter int MAX_ABS_SUM = ssdp_pkg::MAX_ABS_SUM_DEF,
	parameter int ELEM_MAG    = ssdp_pkg::ELEM_MAG_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [ssdp_pkg::TARGET_W-1:0]    cfg_wr_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// element_value [8:0], zero fill [15:9]
	input  logic [ssdp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// found [0], capacity_exceeded [1], element_index [6:2], zero fill [7]
	output logic [ssdp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// is_verdict [0]
	output logic                             m_axis_tuser,
	output logic                             m_axis_tlast
);

	import ssdp_pkg::*;

	localparam int TBL_DEPTH  = 2 * MAX_ABS_SUM + 1;
	localparam int AW         = $clog2(TBL_DEPTH);
	localparam int CW         = $clog2(MAX_ELEMS + 1);
	localparam int SAW        = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
	localparam int SW         = ((AW > TARGET_W) ? AW : TARGET_W) + 2;
	localparam int PW1        = PARENT_W + 1;

	localparam logic signed [SW-1:0] MAG_S    = SW'(ELEM_MAG);
	localparam logic signed [SW-1:0] MAXS_S   = SW'(MAX_ABS_SUM);
	localparam logic signed [SW-1:0] TMAX_S   = SW'(TBL_DEPTH - 1);
	localparam logic [AW-1:0]        TMAX_A   = AW'(TBL_DEPTH - 1);
	localparam logic [AW-1:0]        OFFSET_A = AW'(MAX_ABS_SUM);
	localparam logic [CW-1:0]        FULL_C   = CW'(MAX_ELEMS);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_POST,
		ST_VWAIT,
		ST_VERD,
		ST_BT_RD,
		ST_BT_PAR,
		ST_BT_ELE
	} state_t;

	state_t                    state_q;
	logic [AW-1:0]             clr_q;
	logic [CW-1:0]             count_q;
	logic                      ovf_q;
	logic signed [TARGET_W-1:0] target_q;
	logic signed [ELEM_W-1:0]  elem_q;
	logic [PARENT_W-1:0]       idx_q;
	logic                      last_q;
	logic [AW-1:0]             dest_q;
	logic [AW-1:0]             end_q;
	logic                      issue_s1;
	logic [AW-1:0]             dest_s1;
	logic                      found_q;
	logic [AW-1:0]             pos_q;
	logic [CW-1:0]             steps_q;
	logic [PARENT_W-1:0]       par_q;
	logic                      out_valid_q;
	logic                      out_verdict_q;
	logic                      out_found_q;
	logic                      out_cap_q;
	logic [IDX_W-1:0]          out_idx_q;
	logic                      out_last_q;

	logic                      in_acc;
	logic                      out_free;
	logic                      out_load;
	logic signed [ELEM_W-1:0]  in_val;
	logic signed [SW-1:0]      in_x;
	logic signed [SW-1:0]      in_c_x;
	logic signed [SW-1:0]      abs_x;
	logic signed [SW-1:0]      end_x;
	logic                      skip;
	logic [AW-1:0]             start_a;
	logic [AW-1:0]             end_a;
	logic                      store_full;
	logic signed [SW-1:0]      elem_x;
	logic signed [SW-1:0]      dest_x;
	logic signed [SW-1:0]      src_x;
	logic signed [SW-1:0]      tgt_x;
	logic signed [SW-1:0]      tgt_pos_x;
	logic                      tgt_ok;
	logic [PARENT_W-1:0]       p;
	logic                      p_stop;
	logic signed [ELEM_W-1:0]  store_rd;
	logic signed [SW-1:0]      pos_x;
	logic signed [SW-1:0]      next_x;
	logic [CW-1:0]             steps_nx;
	logic                      bt_last;
	logic                      tbl_we;
	logic [AW-1:0]             tbl_waddr;
	entry_t                    tbl_wdata;
	logic [AW-1:0]             tbl_raddr_a;
	entry_t                    tbl_rd_a;
	entry_t                    tbl_rd_b;
	logic                      st_we;
	logic [SAW-1:0]            st_raddr;

	// handshakes
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = out_free && ((state_q == ST_VERD) || (state_q == ST_BT_ELE));

	// input clamp and scan bounds
	assign in_val     = signed'(s_axis_tdata[ELEM_W-1:0]);
	assign in_x       = SW'(in_val);
	assign in_c_x     = (in_x > MAG_S) ? MAG_S : ((in_x < -MAG_S) ? -MAG_S : in_x);
	assign abs_x      = (in_c_x < 0) ? -in_c_x : in_c_x;
	assign skip       = abs_x > TMAX_S;
	assign end_x      = TMAX_S + in_c_x;
	assign start_a    = (in_c_x >= 0) ? TMAX_A : '0;
	assign end_a      = (in_c_x >= 0) ? in_c_x[AW-1:0] : end_x[AW-1:0];
	assign store_full = (count_q == FULL_C);

	// source entry of the sweep: dest minus element, for either direction
	assign elem_x = SW'(elem_q);
	assign dest_x = SW'(dest_q);
	assign src_x  = dest_x - elem_x;

	// target position and range check
	assign tgt_x     = SW'(target_q);
	assign tgt_ok    = !ovf_q && (tgt_x >= -MAXS_S) && (tgt_x <= MAXS_S);
	assign tgt_pos_x = tgt_x + MAXS_S;

	// chain walk step
	assign p        = tbl_rd_a.parent;
	assign p_stop   = PW1'(p) >= PW1'(count_q);
	assign pos_x    = SW'(pos_q);
	assign next_x   = pos_x - SW'(store_rd);
	assign steps_nx = steps_q + 1'b1;
	assign bt_last  = (next_x == MAXS_S) || (next_x < 0) || (next_x > TMAX_S)
		|| (steps_nx == FULL_C);

	// table write: clearing pass or newly reached sum
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = dest_s1;
		tbl_wdata = '{reach: 1'b1, parent: idx_q};
		if (state_q == ST_CLEAR) begin
			tbl_we    = 1'b1;
			tbl_waddr = clr_q;
			tbl_wdata = '{reach: (clr_q == OFFSET_A), parent: PARENT_NONE};
		end else if (issue_s1 && tbl_rd_b.reach && !tbl_rd_a.reach) begin
			tbl_we = 1'b1;
		end
	end

	// table read address, port a
	always_comb begin
		unique case (state_q)
			ST_POST:  tbl_raddr_a = tgt_pos_x[AW-1:0];
			ST_BT_RD: tbl_raddr_a = pos_q;
			default:  tbl_raddr_a = dest_q;
		endcase
	end

	// element store access
	assign st_we    = in_acc && !store_full;
	assign st_raddr = (state_q == ST_BT_PAR) ? p[SAW-1:0] : par_q[SAW-1:0];

	ssdp_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TBL_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (tbl_we),
		.waddr   (tbl_waddr),
		.wdata   (tbl_wdata),
		.raddr_a (tbl_raddr_a),
		.rdata_a (tbl_rd_a),
		.raddr_b (src_x[AW-1:0]),
		.rdata_b (tbl_rd_b)
	);

	ssdp_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(MAX_ELEMS)
	) u_store (
		.clk     (clk),
		.we      (st_we),
		.waddr   (count_q[SAW-1:0]),
		.wdata   (in_c_x[ELEM_W-1:0]),
		.raddr_a (st_raddr),
		.rdata_a (store_rd),
		.raddr_b (st_raddr),
		.rdata_b ()
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			target_q    <= '0;
			issue_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				target_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			issue_s1 <= (state_q == ST_SCAN);
			dest_s1  <= dest_q;

			unique case (state_q)
				ST_CLEAR: begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					clr_q   <= (clr_q == TMAX_A) ? '0 : clr_q + 1'b1;
					if (clr_q == TMAX_A) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						last_q <= s_axis_tlast;
						if (store_full) begin
							ovf_q   <= 1'b1;
							state_q <= ST_POST;
						end else begin
							elem_q  <= in_c_x[ELEM_W-1:0];
							idx_q   <= PARENT_W'(count_q);
							count_q <= count_q + 1'b1;
							dest_q  <= start_a;
							end_q   <= end_a;
							state_q <= skip ? ST_POST : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (dest_q == end_q) begin
						state_q <= ST_DRAIN;
					end else if (!elem_q[ELEM_W-1]) begin
						dest_q <= dest_q - 1'b1;
					end else begin
						dest_q <= dest_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_POST;
				end
				ST_POST: begin
					state_q <= last_q ? ST_VWAIT : ST_IDLE;
				end
				ST_VWAIT: begin
					found_q <= tgt_ok && tbl_rd_a.reach;
					pos_q   <= tgt_pos_x[AW-1:0];
					state_q <= ST_VERD;
				end
				ST_VERD: begin
					if (out_free) begin
						out_verdict_q <= 1'b1;
						out_found_q   <= found_q;
						out_cap_q     <= ovf_q;
						out_idx_q     <= '0;
						out_last_q    <= !found_q || (pos_q == OFFSET_A);
						steps_q       <= '0;
						state_q       <= (!found_q || (pos_q == OFFSET_A)) ?
							ST_CLEAR : ST_BT_RD;
					end
				end
				ST_BT_RD: begin
					state_q <= ST_BT_PAR;
				end
				ST_BT_PAR: begin
					par_q   <= p;
					state_q <= p_stop ? ST_CLEAR : ST_BT_ELE;
				end
				ST_BT_ELE: begin
					if (out_free) begin
						out_verdict_q <= 1'b0;
						out_found_q   <= 1'b1;
						out_cap_q     <= 1'b0;
						out_idx_q     <= par_q[IDX_W-1:0];
						out_last_q    <= bt_last;
						steps_q       <= steps_nx;
						pos_q         <= next_x[AW-1:0];
						state_q       <= bt_last ? ST_CLEAR : ST_BT_RD;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// result beat
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_idx_q, out_cap_q, out_found_q};
	assign m_axis_tuser  = out_verdict_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// File: sim/ssdp_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdp_result_checker
// Passive checker for the subset-sum solver. It follows target writes and
// accepted element beats, keeps a private reachable-sum table with parent
// links to work out the verdict and the chosen element indices, and
// compares every accepted result beat with the oldest outstanding one.
// ----------------------------------------------------------------------------
module ssdp_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [ssdp_pkg::TARGET_W-1:0]   cfg_wr_data,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	// element_value [8:0], zero fill [15:9]
	input  logic [ssdp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                            s_axis_tlast,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// found [0], capacity_exceeded [1], element_index [6:2], zero fill [7]
	input  logic [ssdp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// is_verdict [0]
	input  logic                            m_axis_tuser,
	input  logic                            m_axis_tlast,
	output int                              mismatch_count,
	output int                              beats_owed
);

	import ssdp_pkg::*;

	localparam int OFFSET = MAX_ABS_SUM_DEF;
	localparam int SPAN   = 2 * MAX_ABS_SUM_DEF + 1;

	typedef struct packed {
		logic             is_verdict;
		logic             found;
		logic             capacity_exceeded;
		logic [IDX_W-1:0] element_index;
		logic             last_result;
	} sol_beat_t;

	// private copy of the solver state
	bit                  reach [SPAN];
	logic [PARENT_W-1:0] parent_of [SPAN];
	int                  held_value [MAX_ELEMS_DEF];
	int                  held_count;
	bit                  overflowed;
	int                  target;
	sol_beat_t           solution_beats [$];
	int                  errs = 0;

	// fresh table: only the zero sum is reachable
	function automatic void clear_table();
		for (int i = 0; i < SPAN; i++) begin
			reach[i]     = 1'b0;
			parent_of[i] = PARENT_NONE;
		end
		reach[OFFSET] = 1'b1;
		held_count    = 0;
		overflowed    = 1'b0;
	endfunction

	// 0/1 knapsack update, sweep direction keeps each element single use
	function automatic void absorb_element(int v, int idx);
		if (v >= 0) begin
			for (int j = SPAN - 1; j >= v; j--) begin
				if (reach[j - v] && !reach[j]) begin
					reach[j]     = 1'b1;
					parent_of[j] = PARENT_W'(idx);
				end
			end
		end else begin
			for (int j = 0; j - v < SPAN; j++) begin
				if (reach[j - v] && !reach[j]) begin
					reach[j]     = 1'b1;
					parent_of[j] = PARENT_W'(idx);
				end
			end
		end
	endfunction

	// verdict beat, then the parent chain from the target down to zero
	function automatic void solve_target();
		sol_beat_t verdict;
		sol_beat_t prev;
		bit        have_prev;
		bit        hit;
		int        pos;
		int        nxt;
		int        steps;
		int        p;
		hit       = 1'b0;
		pos       = 0;
		have_prev = 1'b0;
		prev      = '0;
		if (!overflowed && target >= -MAX_ABS_SUM_DEF && target <= MAX_ABS_SUM_DEF) begin
			pos = target + OFFSET;
			hit = reach[pos];
		end
		verdict.is_verdict        = 1'b1;
		verdict.found             = hit;
		verdict.capacity_exceeded = overflowed;
		verdict.element_index     = '0;
		verdict.last_result       = !hit || pos == OFFSET;
		solution_beats.push_back(verdict);
		if (hit) begin
			steps = 0;
			while (pos != OFFSET && steps < MAX_ELEMS_DEF) begin
				p = int'(parent_of[pos]);
				if (p >= held_count)
					break;
				nxt = pos - held_value[p];
				steps++;
				if (have_prev)
					solution_beats.push_back(prev);
				prev.is_verdict        = 1'b0;
				prev.found             = 1'b1;
				prev.capacity_exceeded = 1'b0;
				prev.element_index     = IDX_W'(p);
				prev.last_result       = nxt == OFFSET || nxt < 0 || nxt >= SPAN;
				have_prev              = 1'b1;
				if (nxt < 0 || nxt >= SPAN)
					break;
				pos = nxt;
			end
			if (have_prev) begin
				prev.last_result = 1'b1;
				solution_beats.push_back(prev);
			end
		end
		clear_table();
	endfunction

	// one element beat: saturate, store while room is left, solve on the last
	function automatic void take_element(logic [ELEM_W-1:0] raw, logic last);
		int v;
		v = int'(signed'(raw));
		if (v > ELEM_MAG_DEF)
			v = ELEM_MAG_DEF;
		if (v < -ELEM_MAG_DEF)
			v = -ELEM_MAG_DEF;
		if (held_count < MAX_ELEMS_DEF) begin
			held_value[held_count] = v;
			absorb_element(v, held_count);
			held_count++;
		end else begin
			overflowed = 1'b1;
		end
		if (last)
			solve_target();
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errs++;
		end
	endfunction

	// follow the config port and both streams
	always @(posedge clk or negedge arst_n) begin
		sol_beat_t seen;
		sol_beat_t want;
		if (!arst_n) begin
			target = 0;
			clear_table();
			solution_beats.delete();
			mismatch_count <= 0;
			beats_owed     <= 0;
		end else begin
			if (cfg_wr_en)
				target = int'(signed'(cfg_wr_data));
			if (s_axis_tvalid && s_axis_tready)
				take_element(s_axis_tdata[ELEM_W-1:0], s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				seen.is_verdict        = m_axis_tuser;
				seen.found             = m_axis_tdata[0];
				seen.capacity_exceeded = m_axis_tdata[1];
				seen.element_index     = m_axis_tdata[2 +: IDX_W];
				seen.last_result       = m_axis_tlast;
				if (solution_beats.size() == 0) begin
					$error("result beat with nothing outstanding: verdict %0d index %0d",
						seen.is_verdict, seen.element_index);
					errs++;
				end else begin
					want = solution_beats.pop_front();
					check_field("is_verdict", want.is_verdict, seen.is_verdict);
					check_field("found", want.found, seen.found);
					check_field("capacity_exceeded", want.capacity_exceeded,
						seen.capacity_exceeded);
					check_field("element_index", want.element_index, seen.element_index);
					check_field("last_result", want.last_result, seen.last_result);
				end
			end
			mismatch_count <= errs;
			beats_owed     <= solution_beats.size();
		end
	end

endmodule

// File: sim/subset_sum_dp_solver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subset_sum_dp_solver_test
// Stimulus and verdict for the subset-sum solver. Short hand-picked sets
// cover the value and target extremes, saturation and out-of-range targets;
// random sets follow, among them a full 32-element chain under a long sink
// stall and an over-capacity set. Checking is done by ssdp_result_checker.
// ----------------------------------------------------------------------------
module subset_sum_dp_solver_test;
	import ssdp_pkg::*;

	localparam int ITEM_GOAL     = 100;
	localparam int HOLD_CYCLES   = 3000;
	// one table sweep plus margin, covers the clearing pass after a set
	localparam int SETTLE_CYCLES = 2 * MAX_ABS_SUM_DEF + 1 + 64;
	// worst quiet stretch is a clearing pass, a settle pause and a sweep
	localparam int IDLE_LIMIT    = 250000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [TARGET_W-1:0]   cfg_wr_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// element_value [8:0], zero fill [15:9]
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// found [0], capacity_exceeded [1], element_index [6:2], zero fill [7]
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// is_verdict [0]
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	int mismatches;
	int owed;
	int items_sent   = 0;
	int holds_asked  = 0;
	int holds_served = 0;
	int quiet_cycles = 0;
	bit calm         = 1'b0;
	int elems [$];

	subset_sum_dp_solver DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	ssdp_result_checker checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast),
		.mismatch_count (mismatches),
		.beats_owed     (owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result sink: random stall bursts, one long hold when asked
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != holds_asked && m_axis_tvalid) begin
				holds_served++;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// one element beat, with an optional gap before it
	task automatic push_element(int v, bit last);
		if (!calm && $urandom_range(0, 2) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W - ELEM_W){1'b0}}, ELEM_W'(v)};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// sender pause until every result is back and the table is cleared
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// send the staged set, optionally writing a new target first
	task automatic play_set(int target, bit retarget, bit hold_sink);
		if (retarget) begin
			drain_results();
			cfg_wr_en   <= 1'b1;
			cfg_wr_data <= TARGET_W'(target);
			@(posedge clk);
			cfg_wr_en   <= 1'b0;
		end
		if (hold_sink)
			holds_asked++;
		foreach (elems[i])
			push_element(elems[i], i == elems.size() - 1);
	endtask

	task automatic stage(int n, int a, int b, int c, int d);
		elems.delete();
		elems.push_back(a);
		if (n > 1) elems.push_back(b);
		if (n > 2) elems.push_back(c);
		if (n > 3) elems.push_back(d);
	endtask

	initial begin
		int n;
		int v;
		int goal;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		arst_n        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// zero target with elements present
		stage(1, 17, 0, 0, 0);        play_set(0, 1'b1, 1'b0);
		// most negative code saturates to the magnitude limit
		stage(1, -256, 0, 0, 0);      play_set(-255, 1'b1, 1'b0);
		stage(3, 255, -255, 255, 0);  play_set(255, 1'b1, 1'b0);
		// targets outside the table range
		stage(2, 1, 0, 0, 0);         play_set(16383, 1'b1, 1'b0);
		stage(1, -1, 0, 0, 0);        play_set(-16384, 1'b1, 1'b0);
		// table edges, unreachable
		stage(2, 255, 255, 0, 0);     play_set(8192, 1'b1, 1'b0);
		stage(1, -128, 0, 0, 0);      play_set(-8192, 1'b1, 1'b0);
		// multi-step chains, positive and negative
		stage(4, 60, 40, -20, 120);   play_set(100, 1'b1, 1'b0);
		stage(3, -200, -100, 50, 0);  play_set(-300, 1'b1, 1'b0);

		// full store of positive values: only the whole set hits the total,
		// so the chain lists every index while the sink holds off
		elems.delete();
		goal = 0;
		for (int i = 0; i < MAX_ELEMS_DEF; i++) begin
			v = $urandom_range(1, ELEM_MAG_DEF);
			elems.push_back(v);
			goal += v;
		end
		play_set(goal, 1'b1, 1'b1);

		// offered straight behind it, same target
		elems.delete();
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++)
			elems.push_back(int'($urandom_range(0, 511)) - 256);
		play_set(goal, 1'b0, 1'b0);

		// over-capacity set
		elems.delete();
		n = MAX_ELEMS_DEF + $urandom_range(1, 3);
		for (int i = 0; i < n; i++)
			elems.push_back(int'($urandom_range(0, 511)) - 256);
		play_set(int'($urandom_range(0, 16384)) - 8192, 1'b1, 1'b0);

		// random small sets, target mostly a sum of a random subset
		while (items_sent < ITEM_GOAL) begin
			elems.delete();
			goal = 0;
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				v = int'($urandom_range(0, 511)) - 256;
				elems.push_back(v);
				if ($urandom_range(0, 1) == 1)
					goal += (v < -ELEM_MAG_DEF) ? -ELEM_MAG_DEF : v;
			end
			if ($urandom_range(0, 3) == 0)
				goal = int'($urandom_range(0, 32767)) - 16384;
			calm = items_sent >= ITEM_GOAL - 12;
			play_set(goal, $urandom_range(0, 3) != 0, 1'b0);
		end

		drain_results();
		if (mismatches == 0 && owed == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
